// ----- hw/rtl/ntpd_pkg.sv -----
// shared types and constants for the ntp disciplined time-of-day unit
`default_nettype none

package ntpd_pkg;

  // seconds between 1900-01-01 and 1970-01-01
  localparam logic [31:0] UnixOffset    = 32'd2208988800;
  localparam logic [11:0] SecsPerHour   = 12'd3600;

  // reset values of the configuration registers
  localparam logic [31:0] AskIntervalRst = 32'd3600000;
  localparam logic [15:0] ReadDelayRst   = 16'd1000;

  // reciprocal constants: x / d == (x * Recip) >> Shift for any 32-bit x
  localparam logic [31:0] Recip1000 = 32'h10624DD3;
  localparam int          Shift1000 = 38;
  localparam logic [31:0] Recip60   = 32'h88888889;
  localparam int          Shift60   = 37;
  localparam logic [31:0] Recip3    = 32'hAAAAAAAB;
  localparam int          Shift3    = 33;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_ZONE_HOURS   = 2'd0,
    REG_TWELVE_HOUR  = 2'd1,
    REG_ASK_INTERVAL = 2'd2,
    REG_READ_DELAY   = 2'd3
  } cfg_reg_t;

  // what the sync stage hands on for one tick
  typedef struct packed {
    logic        send;
    logic [31:0] now;
    logic [31:0] epoch;
    logic [31:0] stamp;
  } sync_t;

  // broken-down time of day
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ntp_disciplined_time_of_day_unit.sv -----
// top level of the ntp disciplined time-of-day unit
// path: an accepted tick transaction passes the input register, the sync stage,
//   the elapsed, seconds and local-time stages and the h/m/s split to out_valid
// throughput: one tick transaction per cycle while out_ready does not stall it,
//   set by the request and reply deadline update in the sync stage
// stall: the whole pipeline holds while a result waits and out_ready is low
// reset: synchronous, clears counters, deadlines, epoch and valid bits
`default_nettype none

module ntp_disciplined_time_of_day_unit (
  input  logic        clk,
  input  logic        rst,

  // configuration writes; the user must write only while the unit is idle, the block does not enforce it
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,

  // one transaction per millisecond tick
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        reply_ready,
  input  logic [31:0] reply_seconds,

  // one result transaction per tick
  output logic        out_valid,
  input  logic        out_ready,
  output logic        send_request,
  output logic        time_valid,
  output logic [31:0] local_seconds,
  output logic [4:0]  hour_out,
  output logic [5:0]  minute_out,
  output logic [5:0]  second_out
);

  localparam int HmsDepth = 4;

  // configuration registers; the zone is kept already scaled to seconds
  logic [31:0] zone_secs;
  logic        twelve_hour_mode;
  logic [31:0] ask_interval_ms;
  logic [15:0] read_delay_ms;
  logic [31:0] zone_ext;

  // whole pipeline moves together; a waiting result holds every stage
  logic        adv;
  logic [9:1]  stage_valid;

  // stage 1: input register
  logic        in_reply_ready;
  logic [31:0] in_reply_seconds;

  // stage 2: sync stage output
  ntpd_pkg::sync_t sync;

  // stage 3: elapsed milliseconds since the request that gave the epoch
  logic        send3;
  logic [31:0] epoch3;
  logic [31:0] elapsed3;

  // stage 4: elapsed whole seconds
  logic [63:0] ms_prod;
  logic        send4;
  logic [31:0] epoch4;
  logic [25:0] elapsed_secs4;

  // stage 5: local seconds, held while the epoch is zero
  logic        send5;
  logic        valid5;
  logic [31:0] held_local_seconds;

  // side pipe matching the h/m/s split
  logic        send_pipe  [HmsDepth];
  logic        valid_pipe [HmsDepth];
  logic [31:0] secs_pipe  [HmsDepth];

  ntpd_pkg::tod_t tod;

  assign adv       = !stage_valid[9] || out_ready;
  // no tick transaction is taken while reset is held
  assign in_ready  = adv && !rst;
  assign out_valid = stage_valid[9];

  assign zone_ext = {{27{cfg_data[4]}}, cfg_data[4:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_secs        <= 32'd0;
      twelve_hour_mode <= 1'b0;
      ask_interval_ms  <= ntpd_pkg::AskIntervalRst;
      read_delay_ms    <= ntpd_pkg::ReadDelayRst;
    end else if (cfg_we) begin
      unique case (ntpd_pkg::cfg_reg_t'(cfg_index))
        ntpd_pkg::REG_ZONE_HOURS:   zone_secs <= zone_ext * {20'd0, ntpd_pkg::SecsPerHour};
        ntpd_pkg::REG_TWELVE_HOUR:  twelve_hour_mode <= cfg_data[0];
        ntpd_pkg::REG_ASK_INTERVAL: ask_interval_ms  <= cfg_data;
        ntpd_pkg::REG_READ_DELAY:   read_delay_ms    <= cfg_data[15:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[8:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_reply_ready   <= reply_ready;
      in_reply_seconds <= reply_seconds;
    end
  end

  ntpd_sync u_sync (
    .clk             (clk),
    .rst             (rst),
    .en              (adv),
    .item_valid      (stage_valid[1]),
    .reply_ready     (in_reply_ready),
    .reply_seconds   (in_reply_seconds),
    .ask_interval_ms (ask_interval_ms),
    .read_delay_ms   (read_delay_ms),
    .sync            (sync)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      send3    <= sync.send;
      epoch3   <= sync.epoch;
      elapsed3 <= sync.now - sync.stamp;
    end
  end

  // divide by 1000 through the reciprocal
  assign ms_prod = 64'(elapsed3) * 64'(ntpd_pkg::Recip1000);

  always_ff @(posedge clk) begin
    if (adv) begin
      send4         <= send3;
      epoch4        <= epoch3;
      elapsed_secs4 <= ms_prod[ntpd_pkg::Shift1000 +: 26];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      send5  <= send4;
      valid5 <= epoch4 != 32'd0;
    end
  end

  // last good local time stays put while no usable epoch is held
  always_ff @(posedge clk) begin
    if (rst) begin
      held_local_seconds <= 32'd0;
    end else if (adv && stage_valid[4] && (epoch4 != 32'd0)) begin
      held_local_seconds <= epoch4 + zone_secs + {6'd0, elapsed_secs4};
    end
  end

  ntpd_hms u_hms (
    .clk         (clk),
    .en          (adv),
    .twelve_hour (twelve_hour_mode),
    .secs        (held_local_seconds),
    .tod         (tod)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      send_pipe[0]  <= send5;
      valid_pipe[0] <= valid5;
      secs_pipe[0]  <= held_local_seconds;
      for (int i = 1; i < HmsDepth; i++) begin
        send_pipe[i]  <= send_pipe[i-1];
        valid_pipe[i] <= valid_pipe[i-1];
        secs_pipe[i]  <= secs_pipe[i-1];
      end
    end
  end

  assign send_request  = send_pipe[HmsDepth-1];
  assign time_valid    = valid_pipe[HmsDepth-1];
  assign local_seconds = secs_pipe[HmsDepth-1];
  assign hour_out      = tod.hour;
  assign minute_out    = tod.minute;
  assign second_out    = tod.second;

endmodule

`default_nettype wire

// ----- hw/rtl/ntpd_sync.sv -----
// request scheduling, reply capture and millisecond counter
`default_nettype none

module ntpd_sync (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           item_valid,
  input  logic           reply_ready,
  input  logic [31:0]    reply_seconds,
  input  logic [31:0]    ask_interval_ms,
  input  logic [15:0]    read_delay_ms,
  output ntpd_pkg::sync_t sync
);

  logic [31:0] ms_counter;
  logic [31:0] ask_deadline;
  logic [31:0] read_deadline;
  logic        reply_taken;
  logic [31:0] epoch_seconds;
  logic [31:0] epoch_stamp;
  logic [31:0] request_stamp;

  logic [31:0] ask_deadline_next;
  logic [31:0] read_deadline_next;
  logic        reply_taken_next;
  logic [31:0] epoch_seconds_next;
  logic [31:0] epoch_stamp_next;
  logic [31:0] request_stamp_next;

  logic        ask_fire;
  logic        send;
  logic [31:0] read_armed;
  logic        read_fire;

  always_comb begin
    ask_fire           = (ms_counter > ask_deadline) || !reply_taken;
    send               = ask_fire && (read_deadline == 32'd0);
    ask_deadline_next  = ask_fire ? ms_counter + ask_interval_ms : ask_deadline;
    read_armed         = send ? ms_counter + {16'd0, read_delay_ms} : read_deadline;
    request_stamp_next = send ? ms_counter : request_stamp;

    // a freshly armed deadline that wrapped past zero fires at once
    read_fire          = (read_armed != 32'd0) && (ms_counter > read_armed);

    read_deadline_next = read_fire ? 32'd0 : read_armed;
    reply_taken_next   = reply_taken;
    epoch_seconds_next = epoch_seconds;
    epoch_stamp_next   = epoch_stamp;
    if (read_fire) begin
      reply_taken_next = reply_ready;
      if (reply_ready) begin
        epoch_seconds_next = reply_seconds - ntpd_pkg::UnixOffset;
        epoch_stamp_next   = request_stamp_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_counter    <= 32'd0;
      ask_deadline  <= 32'd0;
      read_deadline <= 32'd0;
      reply_taken   <= 1'b0;
      epoch_seconds <= 32'd0;
      epoch_stamp   <= 32'd0;
      request_stamp <= 32'd0;
    end else if (en && item_valid) begin
      ms_counter    <= ms_counter + 32'd1;
      ask_deadline  <= ask_deadline_next;
      read_deadline <= read_deadline_next;
      reply_taken   <= reply_taken_next;
      epoch_seconds <= epoch_seconds_next;
      epoch_stamp   <= epoch_stamp_next;
      request_stamp <= request_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sync.send  <= send;
      sync.now   <= ms_counter;
      sync.epoch <= epoch_seconds_next;
      sync.stamp <= epoch_stamp_next;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ntpd_hms.sv -----
// four-stage split of a seconds count into hours, minutes and seconds
`default_nettype none

module ntpd_hms (
  input  logic          clk,
  input  logic          en,
  input  logic          twelve_hour,
  input  logic [31:0]   secs,
  output ntpd_pkg::tod_t tod
);

  // stage a: total minutes
  logic [63:0] q60_prod;
  logic [26:0] q60_a;
  logic [31:0] secs_a;

  // stage b: seconds, total hours
  logic [63:0] qh_prod;
  logic [31:0] q60x60;
  logic [31:0] sec_diff;
  logic [26:0] q60_b;
  logic [20:0] qh_b;
  logic [5:0]  sec_b;

  // stage c: minutes, days
  logic [63:0] qd_prod;
  logic [26:0] qhx60;
  logic [26:0] min_diff;
  logic [20:0] qh_c;
  logic [15:0] qd_c;
  logic [5:0]  min_c;
  logic [5:0]  sec_c;

  // stage d: hour of day
  logic [20:0] qdx24;
  logic [20:0] hour_diff;
  logic [4:0]  hour24;
  logic [4:0]  hour_shown;

  assign q60_prod = 64'(secs) * 64'(ntpd_pkg::Recip60);

  always_ff @(posedge clk) begin
    if (en) begin
      q60_a  <= q60_prod[ntpd_pkg::Shift60 +: 27];
      secs_a <= secs;
    end
  end

  always_comb begin
    qh_prod  = 64'({5'd0, q60_a}) * 64'(ntpd_pkg::Recip60);
    q60x60   = 32'({q60_a, 6'd0}) - 32'({q60_a, 2'd0});
    sec_diff = secs_a - q60x60;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q60_b <= q60_a;
      qh_b  <= qh_prod[ntpd_pkg::Shift60 +: 21];
      sec_b <= sec_diff[5:0];
    end
  end

  // hours modulo 24 is (hours / 8) / 3 taken back out
  always_comb begin
    qd_prod  = 64'({14'd0, qh_b[20:3]}) * 64'(ntpd_pkg::Recip3);
    qhx60    = 27'({qh_b, 6'd0}) - 27'({qh_b, 2'd0});
    min_diff = q60_b - qhx60;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qh_c  <= qh_b;
      qd_c  <= qd_prod[ntpd_pkg::Shift3 +: 16];
      min_c <= min_diff[5:0];
      sec_c <= sec_b;
    end
  end

  always_comb begin
    qdx24     = 21'({qd_c, 4'd0}) + 21'({qd_c, 3'd0});
    hour_diff = qh_c - qdx24;
    hour24    = hour_diff[4:0];
    hour_shown = hour24;
    if (twelve_hour) begin
      if (hour24 == 5'd0) begin
        hour_shown = 5'd12;
      end else if (hour24 > 5'd12) begin
        hour_shown = hour24 - 5'd12;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tod.hour   <= hour_shown;
      tod.minute <= min_c;
      tod.second <= sec_c;
    end
  end

endmodule

`default_nettype wire
